// File: design/lcm_pkg.sv
`default_nettype none

package lcm_pkg;

	typedef logic [15:0] sample_t;
	typedef logic [3:0][15:0] quad_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_THRESHOLD    = 3'd0;
	localparam logic [2:0] REG_BIT_DEPTH    = 3'd1;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PLANE_ENABLE = 3'd4;

	// what an accepted pixel produces
	typedef enum logic [1:0] {
		KIND_NONE,  // rows 0 and 1 of an enabled plane
		KIND_ZERO,  // disabled or short plane: one zero result
		KIND_ONE,   // interior row: mask for row y-2
		KIND_TAIL   // last row: masks for rows y-2, y-1, y
	} kind_t;

	// Mirror row y-d about row 0 and, at the tail, about row y.
	// Returns how many rows above y the sample lives (0..4).
	function automatic logic [2:0] mirror_k(input logic [11:0] y, input logic [3:0] d,
			input logic at_tail);
		logic signed [13:0] ys;
		logic signed [13:0] r;
		logic signed [13:0] k;
		ys = signed'({2'b00, y});
		r = ys - signed'({{10{d[3]}}, d});
		if (r < 0) begin
			r = -r;
		end
		if (at_tail && r > ys) begin
			r = (ys <<< 1) - r;
		end
		k = ys - r;
		return k[2:0];
	endfunction

	// Pick the current pixel or a stored row by its distance above row y.
	function automatic sample_t row_val(input logic [2:0] k, input logic [1:0] yl,
			input sample_t pix, input quad_t rows);
		logic [1:0] slot;
		slot = yl - k[1:0];
		return (k == 3'd0) ? pix : rows[slot];
	endfunction

	// Comb test on a vertical run a,b,c,d,e.
	function automatic logic comb_hit(input sample_t a, input sample_t b, input sample_t c,
			input sample_t d, input sample_t e, input logic [15:0] thr);
		logic signed [17:0] d1;
		logic signed [17:0] d2;
		logic signed [17:0] ts;
		logic signed [20:0] bd;
		logic signed [20:0] v;
		logic signed [20:0] t6;
		logic sign_ok;
		d1 = signed'({2'b00, c}) - signed'({2'b00, b});
		d2 = signed'({2'b00, c}) - signed'({2'b00, d});
		ts = signed'({2'b00, thr});
		sign_ok = (d1 > ts && d2 > ts) || (d1 < -ts && d2 < -ts);
		bd = signed'({5'd0, b}) + signed'({5'd0, d});
		v = signed'({5'd0, a}) + (signed'({5'd0, c}) <<< 2) + signed'({5'd0, e})
			- ((bd <<< 1) + bd);
		if (v < 0) begin
			v = -v;
		end
		t6 = (signed'({5'd0, thr}) <<< 2) + (signed'({5'd0, thr}) <<< 1);
		return sign_ok && (v > t6);
	endfunction

endpackage

`default_nettype wire

// File: design/lcm_line_bank.sv
`default_nettype none

// One row slot of the line store: single write port, registered read-first port.
module lcm_line_bank import lcm_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire sample_t       wdata,
	output sample_t            rdata
);

	sample_t mem [DEPTH];
	sample_t rdata_q;

	// read returns the old contents when the same entry is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/interlace_comb_mask.sv
`default_nettype none

// Comb (interlace) detection mask for one plane streamed in raster order, one pixel per
// transaction. Four line stores hold the previous rows; each pixel is tested against two
// rows above and below (mirrored at the plane edges) and gives zero or all-ones at the
// configured bit depth. Interior rows give one result per pixel, for row y-2; rows 0
// and 1 give none. Each pixel of the last row gives three results (rows y-2, y-1, y),
// which the single output register hands out one result per cycle while m_tready is high.
// A disabled plane, or one under three rows, gives one zero result per pixel. A result
// reaches the output through the stage 1 and stage 2 registers: the line store read and
// the pixel register share the accepting edge, and the output register loads once stage
// 2 is free. The line stores need no clearing after reset. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module interlace_comb_mask import lcm_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] pixel
	// mask output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] mask_value, [27:16] result_row, [31:28] zero
	output logic             m_tlast,   // last_of_run
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int WMAX = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
	localparam int XW = $clog2(WMAX);
	localparam logic [11:0] WCAP = 12'(WMAX);
	localparam int HCAPI = (MAX_HEIGHT < 8191) ? MAX_HEIGHT : 8191;
	localparam logic [12:0] HCAP = 13'(HCAPI);

	// configuration registers
	logic [15:0] threshold_q;
	logic [4:0]  bit_depth_q;
	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        plane_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= 16'd6;
			bit_depth_q    <= 5'd8;
			frame_width_q  <= 12'd640;
			frame_height_q <= 13'd480;
			plane_enable_q <= 1'b1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_THRESHOLD:    threshold_q    <= cfg_data;
				REG_BIT_DEPTH:    bit_depth_q    <= cfg_data[4:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[11:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				REG_PLANE_ENABLE: plane_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturated settings
	logic [4:0]  bd;
	logic [16:0] mask_wide;
	sample_t     mask_all;
	logic [11:0] w;
	logic [12:0] h;

	always_comb begin
		if (bit_depth_q < 5'd8) begin
			bd = 5'd8;
		end else if (bit_depth_q > 5'd16) begin
			bd = 5'd16;
		end else begin
			bd = bit_depth_q;
		end
		mask_wide = (17'd1 << bd) - 17'd1;
		mask_all = mask_wide[15:0];
		if (frame_width_q == 12'd0) begin
			w = 12'd1;
		end else if (frame_width_q > WCAP) begin
			w = WCAP;
		end else begin
			w = frame_width_q;
		end
		if (frame_height_q == 13'd0) begin
			h = 13'd1;
		end else if (frame_height_q > HCAP) begin
			h = HCAP;
		end else begin
			h = frame_height_q;
		end
	end

	// handshake between stages
	logic valid_s1;
	logic valid_s2;
	logic s2_free;
	logic accept;
	logic move;

	assign accept = s_tvalid && s_tready;
	assign move = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// raster position and what the incoming pixel produces
	logic [XW-1:0] x_q;
	logic [11:0]   y_q;
	logic          row_last;
	logic          x_wrap;
	kind_t         kind_in;

	assign row_last = (({1'b0, y_q}) + 13'd1) >= h;
	assign x_wrap = (13'(x_q) + 13'd1) >= {1'b0, w};

	always_comb begin
		if (!plane_enable_q || h < 13'd3) begin
			kind_in = KIND_ZERO;
		end else if (row_last) begin
			kind_in = KIND_TAIL;
		end else if (y_q >= 12'd2) begin
			kind_in = KIND_ONE;
		end else begin
			kind_in = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (x_wrap) begin
				x_q <= '0;
				y_q <= row_last ? 12'd0 : y_q + 12'd1;
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// line store: row r lives in slot r mod 4, all slots read at the current column
	quad_t rows_s1;

	for (genvar i = 0; i < 4; i++) begin : g_bank
		lcm_line_bank #(
			.DEPTH(WMAX),
			.AW(XW)
		) u_bank (
			.clk(clk),
			.we(accept && (y_q[1:0] == 2'(i))),
			.re(accept),
			.addr(x_q),
			.wdata(s_tdata[15:0]),
			.rdata(rows_s1[i])
		);
	end

	// stage 1: pixel and row beside the line store read
	sample_t     pix_s1;
	logic [11:0] y_s1;
	kind_t       kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (kind_in != KIND_NONE);
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_tdata[15:0];
			y_s1    <= y_q;
			kind_s1 <= kind_in;
		end
	end

	// comb test for rows y-2, y-1, y
	logic [2:0][4:0][15:0] nb;
	logic [2:0]            hit;
	logic                  at_tail;

	assign at_tail = (kind_s1 == KIND_TAIL);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int m = 0; m < 5; m++) begin
				nb[j][m] = row_val(mirror_k(y_s1, 4'(4 - j - m), at_tail), y_s1[1:0],
					pix_s1, rows_s1);
			end
			hit[j] = comb_hit(nb[j][0], nb[j][1], nb[j][2], nb[j][3], nb[j][4],
				threshold_q);
		end
	end

	// stage 2: result group, drained one transaction per cycle while m_tready is high
	logic [2:0][15:0] mask_s2;
	logic [2:0][11:0] row_s2;
	logic [1:0]       cnt_s2;
	logic [1:0]       idx_s2;
	logic             grp_end;

	assign grp_end = (idx_s2 == (cnt_s2 - 2'd1));
	assign s2_free = !valid_s2 || (m_tready && grp_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= 2'd0;
			idx_s2   <= 2'd0;
		end else if (move) begin
			valid_s2 <= 1'b1;
			cnt_s2   <= (kind_s1 == KIND_TAIL) ? 2'd3 : 2'd1;
			idx_s2   <= 2'd0;
		end else if (s2_free) begin
			valid_s2 <= 1'b0;
		end else if (m_tready) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	// a zero-plane pixel reports its own row with a zero mask
	always_ff @(posedge clk) begin
		if (move) begin
			for (int j = 0; j < 3; j++) begin
				if (j == 0 && kind_s1 == KIND_ZERO) begin
					mask_s2[j] <= 16'd0;
					row_s2[j]  <= y_s1;
				end else begin
					mask_s2[j] <= hit[j] ? mask_all : 16'd0;
					row_s2[j]  <= y_s1 - 12'd2 + 12'(j);
				end
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {4'd0, row_s2[idx_s2], mask_s2[idx_s2]};
	assign m_tlast = grp_end;

	// the output pointer stays inside its group
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 < cnt_s2))
		else $error("output pointer beyond result group");

	// a tail group carries consecutive rows
	a_tail_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cnt_s2 == 2'd3) |->
			(row_s2[1] == row_s2[0] + 12'd1 && row_s2[2] == row_s2[1] + 12'd1))
		else $error("tail group rows not consecutive");

	// a held stage 1 blocks the input
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |-> !s_tready)
		else $error("input taken while stage 1 is stalled");

	// the column wraps at the end of a row
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_wrap) |=> (x_q == '0))
		else $error("column did not wrap");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import lcm_pkg::*;

	localparam int FRAME_MAX_W = 2048;
	localparam int FRAME_MAX_H = 4096;
	localparam int STALL_LIMIT = 2000;

	// one mask pixel as it leaves the block
	typedef struct packed {
		logic [15:0] mask_value;
		logic [11:0] result_row;
		logic        last_of_run;
	} mask_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;      // [15:0] pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [15:0] mask_value, [27:16] result_row, [31:28] zero
	logic        m_tlast;           // last_of_run
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// shadow of the block: registers, position and line stores
	logic [15:0] cur_thr = 16'd6;
	logic [4:0]  cur_depth = 5'd8;
	logic [11:0] cur_width = 12'd640;
	logic [12:0] cur_height = 13'd480;
	logic        cur_enable = 1'b1;
	int          col_pos = 0;
	int          row_pos = 0;
	sample_t     line_mem [4][FRAME_MAX_W];

	mask_res_t   pending_masks[$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          src_gap_max = 12;
	int          rx_gap_max = 12;
	int          rx_wait = 0;

	interlace_comb_mask u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// effective register values after saturation
	function automatic int eff_depth();
		int d;
		d = int'(cur_depth);
		return (d < 8) ? 8 : ((d > 16) ? 16 : d);
	endfunction

	function automatic int eff_width();
		int w;
		w = int'(cur_width);
		return (w < 1) ? 1 : ((w > FRAME_MAX_W) ? FRAME_MAX_W : w);
	endfunction

	function automatic int eff_height();
		int h;
		h = int'(cur_height);
		return (h < 1) ? 1 : ((h > FRAME_MAX_H) ? FRAME_MAX_H : h);
	endfunction

	// sample of row r at column x, mirrored about row 0 and row lastr
	function automatic int plane_sample(int r, int lastr, int x, int y, sample_t pix);
		int rr;
		rr = (r < 0) ? -r : r;
		if (rr > lastr) begin
			rr = 2 * lastr - rr;
		end
		if (rr < 0) begin
			rr = 0;
		end
		if (rr == y) begin
			return {16'd0, pix};
		end
		return {16'd0, line_mem[rr & 3][x]};
	endfunction

	// comb test on the vertical run centered on row 'row'
	function automatic logic [15:0] comb_mask(int row, int lastr, int x, int y, sample_t pix,
			logic [15:0] ones);
		int a, b, c, d, e, t, d1, d2, v;
		logic hit;
		a = plane_sample(row - 2, lastr, x, y, pix);
		b = plane_sample(row - 1, lastr, x, y, pix);
		c = plane_sample(row, lastr, x, y, pix);
		d = plane_sample(row + 1, lastr, x, y, pix);
		e = plane_sample(row + 2, lastr, x, y, pix);
		t = {16'd0, cur_thr};
		d1 = c - b;
		d2 = c - d;
		hit = (d1 > t && d2 > t) || (d1 < -t && d2 < -t);
		v = a + 4 * c + e - 3 * (b + d);
		if (v < 0) begin
			v = -v;
		end
		return (hit && v > 6 * t) ? ones : 16'd0;
	endfunction

	// expected masks for one accepted pixel, then store it and advance
	function automatic void predict_mask(sample_t pix);
		int x, y, w, h, k, r;
		logic at_last;
		logic [15:0] ones;
		mask_res_t res;
		ones = 16'((17'd1 << eff_depth()) - 17'd1);
		w = eff_width();
		h = eff_height();
		x = col_pos;
		y = row_pos;
		at_last = (y + 1 >= h);
		if (!cur_enable || h < 3) begin
			res = '{16'd0, 12'(y), 1'b1};
			pending_masks.push_back(res);
		end else if (at_last) begin
			for (k = 0; k < 3; k++) begin
				r = y - 2 + k;
				res = '{comb_mask(r, y, x, y, pix, ones), 12'(r), (k == 2)};
				pending_masks.push_back(res);
			end
		end else if (y >= 2) begin
			res = '{comb_mask(y - 2, y + 2, x, y, pix, ones), 12'(y - 2), 1'b1};
			pending_masks.push_back(res);
		end
		line_mem[y & 3][x] = pix;
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = at_last ? 0 : ((row_pos + 1) & 12'hFFF);
		end
	endfunction

	// check each mask pixel against the oldest expectation
	always @(posedge clk) begin
		mask_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait = $urandom_range(0, rx_gap_max);
			if (pending_masks.size() == 0) begin
				$error("unexpected mask result: data %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_masks.pop_front();
				if (m_tdata[15:0] !== want.mask_value) begin
					$error("mask_value: expected %h, actual %h", want.mask_value, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[27:16] !== want.result_row) begin
					$error("result_row: expected %0d, actual %0d", want.result_row,
						m_tdata[27:16]);
					errors++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %b, actual %b", want.last_of_run, m_tlast);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: too long without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL interlace_comb_mask");
			$finish;
		end
	end

	task automatic send_pixel(input sample_t pix);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_mask(pix);
	endtask

	// stop sending and let every expected mask come out
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD:    cur_thr = data;
			REG_BIT_DEPTH:    cur_depth = data[4:0];
			REG_FRAME_WIDTH:  cur_width = data[11:0];
			REG_FRAME_HEIGHT: cur_height = data[12:0];
			REG_PLANE_ENABLE: cur_enable = data[0];
			default: ;
		endcase
	endtask

	// block must be idle here
	task automatic set_config(input logic [15:0] thr, input logic [15:0] depth,
			input logic [15:0] width, input logic [15:0] height, input logic [15:0] enable);
		cfg_write(REG_THRESHOLD, thr);
		cfg_write(REG_BIT_DEPTH, depth);
		cfg_write(REG_FRAME_WIDTH, width);
		cfg_write(REG_FRAME_HEIGHT, height);
		cfg_write(REG_PLANE_ENABLE, enable);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// interlaced-looking sample: bright and dark rows with noise, some pure noise
	function automatic sample_t comb_pixel(int r);
		int top, noise;
		top = (1 << eff_depth()) - 1;
		if ($urandom_range(0, 3) == 0) begin
			return sample_t'($urandom);
		end
		noise = $urandom_range(0, top / 8);
		return sample_t'(r[0] ? noise : top - noise);
	endfunction

	// one whole plane; optional drain before pixel number pause_at
	task automatic run_frame(input int pause_at, output int sent);
		int w, h, r, c, flip;
		w = eff_width();
		h = eff_height();
		flip = $urandom_range(0, 1);
		sent = 0;
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				if (sent == pause_at) begin
					wait_idle();
				end
				send_pixel(comb_pixel(r + flip));
				sent++;
			end
		end
		wait_idle();
	endtask

	task automatic test_directed();
		sample_t pix [15] = '{
			16'h0000, 16'hFFFF, 16'h0001,
			16'hFFFF, 16'h0000, 16'h8000,
			16'h0000, 16'hFFFF, 16'h7FFF,
			16'hFFFF, 16'h0000, 16'hFFFE,
			16'h0000, 16'hFFFF, 16'hAAAA
		};
		int i;
		// enabled plane: first two rows, interior rows, tail with mirroring
		set_config(16'd0, 16'd16, 16'd3, 16'd5, 16'd1);
		for (i = 0; i < 15; i++) begin
			send_pixel(pix[i]);
		end
		wait_idle();
		// short plane gives zeros
		set_config(16'd6, 16'd8, 16'd2, 16'd2, 16'd1);
		for (i = 0; i < 4; i++) begin
			send_pixel(sample_t'($urandom));
		end
		wait_idle();
		// disabled plane gives zeros
		set_config(16'd6, 16'd9, 16'd2, 16'd3, 16'd0);
		for (i = 0; i < 6; i++) begin
			send_pixel(sample_t'($urandom));
		end
		wait_idle();
	endtask

	task automatic test_limits();
		int i, sent;
		// everything saturated low, maximum threshold, one-row planes
		set_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1);
		for (i = 0; i < 3; i++) begin
			send_pixel(sample_t'($urandom));
		end
		wait_idle();
		// depth saturated high; large threshold where 6*t no longer fits 16 bits
		set_config(16'd20000, 16'd31, 16'd4, 16'd3, 16'd1);
		run_frame(-1, sent);
	endtask

	task automatic test_random_frames();
		int done_items, sent, pause_at;
		logic [15:0] thr, depth, width, height;
		done_items = 0;
		while (done_items < 100) begin
			case ($urandom_range(0, 9))
				0: thr = 16'd0;
				1: thr = 16'($urandom);
				2: thr = 16'($urandom_range(1000, 20000));
				default: thr = 16'($urandom_range(0, 64));
			endcase
			depth = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 31))
				: 16'($urandom_range(8, 16));
			width = 16'($urandom_range(1, 8));
			height = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2))
				: 16'($urandom_range(3, 7));
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			set_config(thr, depth, width, height, 16'($urandom_range(0, 7) != 0));
			// the first frame always picks a drain point, anywhere from pixel 1 to past the last pixel
			if (done_items == 0 || $urandom_range(0, 3) == 0) begin
				pause_at = $urandom_range(1, eff_width() * eff_height());
			end else begin
				pause_at = -1;
			end
			run_frame(pause_at, sent);
			done_items += sent;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_limits();
		test_random_frames();
		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_masks.size() != 0) begin
			$error("%0d expected mask results never arrived", pending_masks.size());
			errors++;
		end
		if (errors == 0) begin
			$display("PASS interlace_comb_mask");
		end else begin
			$display("FAIL interlace_comb_mask");
		end
		$finish;
	end

endmodule
